// File: hdl/sssq_pkg.sv
`default_nettype none

package sssq_pkg;

   localparam int TIME_BITS  = 32;
   localparam int STICK_BITS = 16;

   localparam logic [TIME_BITS-1:0] WATCHDOG_MS = TIME_BITS'(500);
   localparam logic [TIME_BITS-1:0] FRESH_MS    = TIME_BITS'(250);

   localparam logic [15:0] STICK_LOW_MASK = 16'((32'd1 << (16 - STICK_BITS)) - 32'd1);

   localparam int REQ_DATA_BITS = 152;
   localparam int RSP_DATA_BITS = 88;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [2:0] {
      FUNC_TICK  = 3'd0,
      FUNC_TAKE  = 3'd1,
      FUNC_CHECK = 3'd2,
      FUNC_DROP  = 3'd3,
      FUNC_FIRE  = 3'd4
   } func_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_ENABLE      = 3'd0,
      REG_STEP_UNITS  = 3'd1,
      REG_FIRE_LEVEL  = 3'd2,
      REG_REARM_LEVEL = 3'd3,
      REG_REPEAT_MS   = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      VERDICT_NONE    = 2'd0,
      VERDICT_HONORED = 2'd1,
      VERDICT_IGNORED = 2'd2
   } verdict_type;

endpackage

`default_nettype wire

// File: hdl/stick_snap_step_qualifier_unit.sv
`default_nettype none

// Snap-turn step qualifier.
// The req_ channel carries one item per transfer: the function code in req_tuser and the
// stick, time, writer and yaw fields in req_tdata. Every item produces exactly one result
// on the rsp_ channel. Registers are written through the csr_ port, one register per cycle
// with csr_we high; the user must write them only while no item is in flight, which the
// block itself does not enforce. An item is accepted when req_tvalid and req_tready are
// both high; its result is in the output register on the next cycle. All state updates
// of an item are done by the logic between the input ports and the output register, so
// the block sustains one item per clock while the receiver does not stall.
// When the receiver stalls, the result holds in the output register and req_tready drops;
// a new item is taken in the same cycle that the waiting result transfers.
// Synchronous reset empties the output register, sets the armed flag, clears the pending
// total, the time stamps and the honor check, and returns all registers to their defaults.
module stick_snap_step_qualifier_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // stick_x[15:0], stick_would_turn[16], controllers_active[17], writer_ok[18],
   // writer_stamp_ms[50:19], now_ms[82:51], incoming_yaw[114:83], have_prev_write[115],
   // prev_write_yaw[147:116], step_left[148], zero[151:149]
   input  wire [sssq_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // func[2:0]
   input  wire [2:0]                          req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // lane_open[0], eat_stick[1], fired_step[18:2], pending_total[50:19],
   // taken_step[82:51], dropped[83], honour_result[85:84], armed_now[86], zero[87]
   output logic [sssq_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  wire                                csr_we,
   input  wire [sssq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire [sssq_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import sssq_pkg::*;

   logic                 enable_ff;
   logic [15:0]          step_units_ff;
   logic [14:0]          fire_level_ff;
   logic [14:0]          rearm_level_ff;
   logic [10:0]          repeat_ms_ff;

   logic                 armed_ff, armed_in;
   logic [TIME_BITS-1:0] last_fire_ff, last_fire_in;
   logic signed [31:0]   pending_ff, pending_in;
   logic [TIME_BITS-1:0] queued_ff, queued_in;
   logic signed [31:0]   check_step_ff, check_step_in;
   logic                 check_pending_ff, check_pending_in;

   logic                 rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                 accept;
   func_type             func;
   logic signed [15:0]   stick_x;
   logic                 would_turn, ctl_active, writer_ok, have_prev, step_left;
   logic [TIME_BITS-1:0] stamp, now;
   logic signed [31:0]   incoming_yaw, prev_yaw;

   logic [16:0]          abs_x;
   logic                 lane, eat, drop, do_fire, fire_neg;
   logic signed [16:0]   fired;
   logic signed [31:0]   taken, pending_base;
   logic signed [32:0]   pending_sum;
   logic signed [31:0]   pending_sat;
   logic [1:0]           verdict;
   logic signed [15:0]   drift;
   logic [16:0]          abs_drift;
   logic [32:0]          abs_check;
   logic                 below_rearm, at_fire, repeat_due, watchdog_hit;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign func         = func_type'(req_tuser);
   assign stick_x      = signed'(req_tdata[15:0] & ~STICK_LOW_MASK);
   assign would_turn   = req_tdata[16];
   assign ctl_active   = req_tdata[17];
   assign writer_ok    = req_tdata[18];
   assign stamp        = TIME_BITS'(req_tdata[50:19]);
   assign now          = TIME_BITS'(req_tdata[82:51]);
   assign incoming_yaw = signed'(req_tdata[114:83]);
   assign have_prev    = req_tdata[115];
   assign prev_yaw     = signed'(req_tdata[147:116]);
   assign step_left    = req_tdata[148];

   always_comb begin
      abs_x = stick_x[15] ? 17'(-{stick_x[15], stick_x}) : 17'({1'b0, stick_x});
      lane = enable_ff && ctl_active && writer_ok && ((now - stamp) < FRESH_MS);
      below_rearm = abs_x < {2'b00, rearm_level_ff};
      at_fire = abs_x >= {2'b00, fire_level_ff};
      repeat_due = (repeat_ms_ff != 11'd0)
         && ((now - last_fire_ff) >= TIME_BITS'(repeat_ms_ff));
      watchdog_hit = (pending_ff != 32'sd0) && ((now - queued_ff) > WATCHDOG_MS);

      drift = 16'(incoming_yaw - prev_yaw);
      abs_drift = drift[15] ? 17'(-{drift[15], drift}) : 17'({1'b0, drift});
      abs_check = check_step_ff[31] ? 33'(-{check_step_ff[31], check_step_ff})
                                    : {1'b0, check_step_ff};

      armed_in = armed_ff;
      last_fire_in = last_fire_ff;
      queued_in = queued_ff;
      check_step_in = check_step_ff;
      check_pending_in = check_pending_ff;
      pending_base = pending_ff;
      eat = 1'b0;
      drop = 1'b0;
      do_fire = 1'b0;
      fire_neg = !(stick_x > 16'sd0);
      taken = 32'sd0;
      verdict = VERDICT_NONE;

      case (func)
         FUNC_TICK: begin
            if (watchdog_hit) begin
               pending_base = 32'sd0;
               drop = 1'b1;
            end
            if (!lane || !would_turn) begin
               armed_in = below_rearm;
            end else begin
               eat = 1'b1;
               if (armed_ff && at_fire) begin
                  do_fire = 1'b1;
                  armed_in = 1'b0;
               end else if (!armed_ff && below_rearm) begin
                  armed_in = 1'b1;
               end else if (!armed_ff && at_fire && repeat_due) begin
                  do_fire = 1'b1;
               end
            end
         end
         FUNC_TAKE: begin
            taken = pending_ff;
            pending_base = 32'sd0;
            if (pending_ff != 32'sd0) begin
               check_step_in = pending_ff;
               check_pending_in = 1'b1;
            end
         end
         FUNC_CHECK: begin
            if (check_pending_ff) begin
               check_pending_in = 1'b0;
               if (have_prev) begin
                  verdict = ({15'd0, abs_drift} < abs_check[32:1]) ? VERDICT_HONORED
                                                                   : VERDICT_IGNORED;
               end
            end
         end
         FUNC_DROP: begin
            if (pending_ff != 32'sd0) begin
               pending_base = 32'sd0;
               drop = 1'b1;
            end
         end
         FUNC_FIRE: begin
            do_fire = 1'b1;
            fire_neg = step_left;
         end
         default: begin
         end
      endcase

      fired = 17'sd0;
      if (do_fire) begin
         fired = fire_neg ? 17'(-{1'b0, step_units_ff}) : 17'({1'b0, step_units_ff});
         last_fire_in = now;
         queued_in = now;
      end
      pending_sum = 33'(pending_base) + 33'(fired);
      if (pending_sum > 33'sh0_7FFF_FFFF) begin
         pending_sat = 32'sh7FFF_FFFF;
      end else if (pending_sum < -33'sh0_8000_0000) begin
         pending_sat = 32'sh8000_0000;
      end else begin
         pending_sat = pending_sum[31:0];
      end
      pending_in = pending_sat;

      rsp_data_in = {1'b0, armed_in, verdict, drop, taken, pending_in, fired, eat, lane};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         step_units_ff <= 16'd8192;
         fire_level_ff <= 15'd19661;
         rearm_level_ff <= 15'd9830;
         repeat_ms_ff <= 11'd0;
         armed_ff <= 1'b1;
         last_fire_ff <= '0;
         pending_ff <= 32'sd0;
         queued_ff <= '0;
         check_step_ff <= 32'sd0;
         check_pending_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            last_fire_ff <= last_fire_in;
            pending_ff <= pending_in;
            queued_ff <= queued_in;
            check_step_ff <= check_step_in;
            check_pending_ff <= check_pending_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we && (reg_index_type'(csr_index) == REG_ENABLE)) begin
            armed_ff <= 1'b0;
         end else if (accept) begin
            armed_ff <= armed_in;
         end
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_ENABLE: begin
                  enable_ff <= csr_wdata[0];
               end
               REG_STEP_UNITS: begin
                  step_units_ff <= csr_wdata;
               end
               REG_FIRE_LEVEL: begin
                  fire_level_ff <= csr_wdata[14:0];
               end
               REG_REARM_LEVEL: begin
                  rearm_level_ff <= csr_wdata[14:0];
               end
               REG_REPEAT_MS: begin
                  repeat_ms_ff <= csr_wdata[10:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/sssq_checker.sv
`default_nettype none

module sssq_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_tvalid,
   input wire                                req_tready,
   input wire                                rsp_tvalid,
   input wire                                rsp_tready,
   input wire [sssq_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import sssq_pkg::*;

   // A result that is not taken stays put with its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result changed before its transfer.");

   // Every accepted item shows its result on the next cycle.
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("Accepted item produced no result.");

   // A stalled output blocks intake.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("Input accepted while the output was stalled.");

   // The stick is only withheld while the lane is open.
   a_eat_lane: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("Stick withheld with the lane closed.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result pending after reset.");

endmodule

bind stick_snap_step_qualifier_unit sssq_checker u_sssq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: bench/stick_snap_step_qualifier_unit_test.sv
module stick_snap_step_qualifier_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sssq_pkg::*;

   localparam logic [2:0] FUNC_NOP     = 3'd5;
   localparam logic [2:0] FUNC_NOP_TOP = 3'd7;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NONE = 3'd7;

   typedef struct {
      logic [2:0]         func;
      logic signed [15:0] stick_x;
      logic               turn;
      logic               ctl;
      logic               wok;
      logic [31:0]        stamp;
      logic [31:0]        now;
      logic signed [31:0] incoming;
      logic               have_prev;
      logic signed [31:0] prev;
      logic               left;
   } snap_item_type;

   typedef struct {
      logic        lane;
      logic        eat;
      logic [16:0] fired;
      logic [31:0] pending;
      logic [31:0] taken;
      logic        dropped;
      logic [1:0]  verdict;
      logic        armed;
   } snap_result_type;

   typedef enum {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      snap_item_type             item;
      logic [CSR_INDEX_BITS-1:0] csr_index;
      logic [CSR_DATA_BITS-1:0]  csr_value;
      bit                        typed;
      snap_result_type           result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   stick_snap_step_qualifier_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Predictor copy of the registers and of the block state.
   bit          cfg_enable = 1'b0;
   logic [15:0] cfg_step   = 16'd8192;
   logic [14:0] cfg_fire   = 15'd19661;
   logic [14:0] cfg_rearm  = 15'd9830;
   logic [10:0] cfg_repeat = 11'd0;

   bit          st_armed         = 1'b1;
   logic [31:0] st_last_fire     = '0;
   longint      st_pending       = 0;
   logic [31:0] st_queued        = '0;
   longint      st_check         = 0;
   bit          st_check_pending = 1'b0;

   snap_result_type awaited_results[$];
   stim_row_type    stim_table[$];

   int errors = 0;
   int items_done = 0;
   int results_seen = 0;
   int n_fired = 0;
   int n_drops = 0;
   int n_verdicts = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_count = 0;

   logic [31:0]        rnd_now = '0;
   logic signed [15:0] rnd_stick = '0;
   int                 hold_left = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic snap_result_type quiet_result(bit armed_flag);
      snap_result_type r;
      r.lane    = 1'b0;
      r.eat     = 1'b0;
      r.fired   = '0;
      r.pending = '0;
      r.taken   = '0;
      r.dropped = 1'b0;
      r.verdict = VERDICT_NONE;
      r.armed   = armed_flag;
      return r;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint queue_snap(bit negative, logic [31:0] now);
      longint u;
      u = negative ? -longint'(cfg_step) : longint'(cfg_step);
      st_pending = clamp32(st_pending + u);
      st_queued = now;
      st_last_fire = now;
      return u;
   endfunction

   function automatic snap_result_type predict_snap_result(snap_item_type it);
      snap_result_type r;
      logic signed [15:0] xs;
      logic [31:0] diff;
      logic signed [15:0] d16;
      longint x, ax, fired, taken, drift, ad, mag_step;
      bit lane;
      r = quiet_result(1'b0);
      fired = 0;
      taken = 0;
      lane = cfg_enable && it.ctl && it.wok && ((it.now - it.stamp) < FRESH_MS);
      xs = it.stick_x & ~STICK_LOW_MASK;
      x = xs;
      ax = (x < 0) ? -x : x;
      case (it.func)
         FUNC_TICK: begin
            if (st_pending != 0 && (it.now - st_queued) > WATCHDOG_MS) begin
               st_pending = 0;
               r.dropped = 1'b1;
            end
            if (!lane || !it.turn) begin
               st_armed = ax < longint'(cfg_rearm);
            end else begin
               r.eat = 1'b1;
               if (st_armed && ax >= longint'(cfg_fire)) begin
                  fired = queue_snap(!(x > 0), it.now);
                  st_armed = 1'b0;
               end else if (!st_armed && ax < longint'(cfg_rearm)) begin
                  st_armed = 1'b1;
               end else if (!st_armed && cfg_repeat != 0 && ax >= longint'(cfg_fire) &&
                            (it.now - st_last_fire) >= 32'(cfg_repeat)) begin
                  fired = queue_snap(!(x > 0), it.now);
               end
            end
         end
         FUNC_TAKE: begin
            taken = st_pending;
            st_pending = 0;
            if (taken != 0) begin
               st_check = taken;
               st_check_pending = 1'b1;
            end
         end
         FUNC_CHECK: begin
            if (st_check_pending) begin
               st_check_pending = 1'b0;
               if (it.have_prev) begin
                  diff = it.incoming - it.prev;
                  d16 = diff[15:0];
                  drift = d16;
                  ad = (drift < 0) ? -drift : drift;
                  mag_step = (st_check < 0) ? -st_check : st_check;
                  r.verdict = (ad < mag_step / 2) ? VERDICT_HONORED : VERDICT_IGNORED;
               end
            end
         end
         FUNC_DROP: begin
            if (st_pending != 0) begin
               st_pending = 0;
               r.dropped = 1'b1;
            end
         end
         FUNC_FIRE: begin
            fired = queue_snap(it.left, it.now);
         end
         default: ;
      endcase
      r.lane    = lane;
      r.fired   = fired[16:0];
      r.pending = st_pending[31:0];
      r.taken   = taken[31:0];
      r.armed   = st_armed;
      return r;
   endfunction

   function automatic snap_item_type lane_item(logic [2:0] func, logic [15:0] stick,
                                               logic [31:0] now);
      snap_item_type it;
      it.func      = func;
      it.stick_x   = stick;
      it.turn      = 1'b1;
      it.ctl       = 1'b1;
      it.wok       = 1'b1;
      it.stamp     = now;
      it.now       = now;
      it.incoming  = '0;
      it.have_prev = 1'b0;
      it.prev      = '0;
      it.left      = 1'b0;
      return it;
   endfunction

   function automatic snap_item_type random_item();
      snap_item_type it;
      int mag, lo, hi, pick;
      bit neg;
      pick = $urandom_range(99);
      if (pick < 68) it.func = FUNC_TICK;
      else if (pick < 76) it.func = FUNC_TAKE;
      else if (pick < 84) it.func = FUNC_CHECK;
      else if (pick < 88) it.func = FUNC_DROP;
      else if (pick < 95) it.func = FUNC_FIRE;
      else it.func = 3'($urandom_range(FUNC_NOP, FUNC_NOP_TOP));
      pick = $urandom_range(99);
      if (pick < 10) rnd_now = rnd_now;
      else if (pick < 78) rnd_now += $urandom_range(1, 40);
      else if (pick < 88) rnd_now += $urandom_range(100, 300);
      else if (pick < 97) rnd_now += $urandom_range(450, 700);
      else rnd_now = $urandom;
      if (hold_left == 0) begin
         hold_left = ($urandom_range(3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 20);
         lo = (cfg_rearm < cfg_fire) ? cfg_rearm : cfg_fire;
         hi = (cfg_rearm < cfg_fire) ? cfg_fire : cfg_rearm;
         neg = 1'($urandom_range(1));
         pick = $urandom_range(3);
         case ($urandom_range(5))
            0: mag = (cfg_rearm == 0) ? 0 : $urandom_range(0, cfg_rearm - 1);
            1: mag = $urandom_range(lo, hi);
            2: mag = $urandom_range(cfg_fire, 32768);
            3: mag = -1;
            4: mag = 32768;
            default: mag = (pick == 0) ? cfg_fire - 1 : (pick == 1) ? cfg_fire :
                           (pick == 2) ? cfg_rearm - 1 : cfg_rearm;
         endcase
         if (mag < 0) rnd_stick = 16'($urandom);
         else if (neg) rnd_stick = 16'(-mag);
         else rnd_stick = (mag > 32767) ? 16'sd32767 : 16'(mag);
      end else begin
         hold_left--;
      end
      it.stick_x   = rnd_stick;
      it.now       = rnd_now;
      it.stamp     = ($urandom_range(99) < 85) ? rnd_now - $urandom_range(0, 260) : $urandom;
      it.turn      = $urandom_range(99) < 85;
      it.ctl       = $urandom_range(99) < 92;
      it.wok       = $urandom_range(99) < 92;
      it.prev      = $urandom;
      it.incoming  = ($urandom_range(3) == 0) ? $urandom :
                     it.prev + $urandom_range(0, 2 * cfg_step) - cfg_step;
      it.have_prev = $urandom_range(99) < 80;
      it.left      = 1'($urandom_range(1));
      return it;
   endfunction

   task automatic add_item(input snap_item_type it);
      stim_row_type row;
      row.kind = ROW_ITEM;
      row.item = it;
      row.csr_index = '0;
      row.csr_value = '0;
      row.typed = 1'b0;
      row.result = quiet_result(1'b0);
      stim_table.push_back(row);
   endtask

   task automatic add_typed(input snap_item_type it, input snap_result_type r);
      stim_row_type row;
      row.kind = ROW_ITEM;
      row.item = it;
      row.csr_index = '0;
      row.csr_value = '0;
      row.typed = 1'b1;
      row.result = r;
      stim_table.push_back(row);
   endtask

   task automatic add_csr(input logic [CSR_INDEX_BITS-1:0] index,
                          input logic [CSR_DATA_BITS-1:0] value);
      stim_row_type row;
      row.kind = ROW_CSR;
      row.item = lane_item(FUNC_NOP, '0, '0);
      row.csr_index = index;
      row.csr_value = value;
      row.typed = 1'b0;
      row.result = quiet_result(1'b0);
      stim_table.push_back(row);
   endtask

   // Registers change only with the input channel quiet and every result drained.
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         REG_ENABLE: begin
            cfg_enable = value[0];
            st_armed = 1'b0;
         end
         REG_STEP_UNITS:  cfg_step = value;
         REG_FIRE_LEVEL:  cfg_fire = value[14:0];
         REG_REARM_LEVEL: cfg_rearm = value[14:0];
         REG_REPEAT_MS:   cfg_repeat = value[10:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_levels(input bit en, input int step, input int fire, input int rearm,
                             input int rep);
      write_csr(REG_ENABLE, 16'(en));
      write_csr(REG_STEP_UNITS, 16'(step));
      write_csr(REG_FIRE_LEVEL, 16'(fire));
      write_csr(REG_REARM_LEVEL, 16'(rearm));
      write_csr(REG_REPEAT_MS, 16'(rep));
   endtask

   task automatic set_random_levels();
      set_levels($urandom_range(7) != 0, $urandom_range(910, 32768), $urandom_range(9830, 31130),
                 $urandom_range(1638, 29491),
                 ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 400));
   endtask

   task automatic deliver(input snap_item_type it, input bit typed,
                          input snap_result_type typed_r);
      snap_result_type prd;
      req_tuser <= it.func;
      req_tdata <= {3'b000, it.left, it.prev, it.have_prev, it.incoming, it.now, it.stamp,
                    it.wok, it.ctl, it.turn, it.stick_x};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      prd = predict_snap_result(it);
      awaited_results.push_back(typed ? typed_r : prd);
      items_done++;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_count = 300;
      end
      if (hold_count > 0) begin
         hold_count--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      snap_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.lane    = rsp_tdata[0];
         got.eat     = rsp_tdata[1];
         got.fired   = rsp_tdata[18:2];
         got.pending = rsp_tdata[50:19];
         got.taken   = rsp_tdata[82:51];
         got.dropped = rsp_tdata[83];
         got.verdict = rsp_tdata[85:84];
         got.armed   = rsp_tdata[86];
         results_seen++;
         if (awaited_results.size() == 0) begin
            errors++;
            $display("%0t ns: result with nothing expected, expected none, actual %h",
                     $time, rsp_tdata);
         end else begin
            want = awaited_results.pop_front();
            check_field("lane_open", want.lane, got.lane);
            check_field("eat_stick", want.eat, got.eat);
            check_field("fired_step", want.fired, got.fired);
            check_field("pending_total", want.pending, got.pending);
            check_field("taken_step", want.taken, got.taken);
            check_field("dropped", want.dropped, got.dropped);
            check_field("honour_result", want.verdict, got.verdict);
            check_field("armed_now", want.armed, got.armed);
            if (want.fired != 0) n_fired++;
            if (want.dropped) n_drops++;
            if (want.verdict != VERDICT_NONE) n_verdicts++;
         end
      end
   end

   initial begin
      snap_item_type t;
      snap_result_type none;
      int send_pcts[4];
      int stall_pcts[4];
      int counted;
      int directed_items;
      none = quiet_result(1'b0);
      send_pcts = '{0, 47, 0, 21};
      stall_pcts = '{0, 0, 47, 21};

      t = lane_item(FUNC_TICK, 16'sd0, 32'd1000);
      add_typed(t, quiet_result(1'b1));
      t = lane_item(FUNC_NOP, 16'sd0, 32'd1000);
      add_typed(t, quiet_result(1'b1));
      t = lane_item(FUNC_CHECK, 16'sd0, 32'd1000);
      t.have_prev = 1'b1;
      add_typed(t, quiet_result(1'b1));
      t = lane_item(FUNC_TAKE, 16'sd0, 32'd1000);
      add_typed(t, quiet_result(1'b1));
      add_csr(REG_ENABLE, 16'd1);
      add_csr(REG_NONE, 16'hFFFF);
      add_item(lane_item(FUNC_TICK, 16'sd0, 32'd1010));
      add_item(lane_item(FUNC_TICK, 16'sh7FFF, 32'd1020));
      add_item(lane_item(FUNC_TICK, 16'sh7FFF, 32'd1030));
      add_item(lane_item(FUNC_TICK, 16'sd0, 32'd1050));
      add_item(lane_item(FUNC_TICK, 16'sh8000, 32'd1060));
      t = lane_item(FUNC_TICK, 16'sd0, 32'd1070);
      t.turn = 1'b0;
      add_item(t);
      t = lane_item(FUNC_TICK, 16'sh7FFF, 32'd1080);
      t.stamp = 32'd1081;
      add_item(t);
      add_item(lane_item(FUNC_FIRE, 16'sd0, 32'd1100));
      add_item(lane_item(FUNC_FIRE, 16'sd0, 32'd1110));
      add_item(lane_item(FUNC_TAKE, 16'sd0, 32'd1115));
      t = lane_item(FUNC_CHECK, 16'sd0, 32'd1120);
      t.have_prev = 1'b1;
      t.prev = 32'sh8000_0000;
      t.incoming = 32'sh8000_0064;
      add_item(t);
      t = lane_item(FUNC_FIRE, 16'sd0, 32'd1200);
      t.left = 1'b1;
      add_item(t);
      add_item(lane_item(FUNC_TAKE, 16'sd0, 32'd1205));
      t = lane_item(FUNC_CHECK, 16'sd0, 32'd1210);
      t.have_prev = 1'b1;
      t.prev = 32'sh7FFF_FFFF;
      t.incoming = 32'sh8000_4E1F;
      add_item(t);
      add_item(lane_item(FUNC_FIRE, 16'sd0, 32'd1300));
      add_item(lane_item(FUNC_TAKE, 16'sd0, 32'd1305));
      add_item(lane_item(FUNC_CHECK, 16'sd0, 32'd1310));
      add_item(lane_item(FUNC_FIRE, 16'sd0, 32'd1400));
      add_item(lane_item(FUNC_DROP, 16'sd0, 32'd1410));
      add_item(lane_item(FUNC_DROP, 16'sd0, 32'd1420));
      add_item(lane_item(FUNC_FIRE, 16'sd0, 32'd2000));
      add_item(lane_item(FUNC_TICK, 16'sd0, 32'd2501));
      add_csr(REG_FIRE_LEVEL, 16'd0);
      add_item(lane_item(FUNC_TICK, 16'sd0, 32'd2510));
      add_csr(REG_FIRE_LEVEL, 16'd19661);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_CSR)
            write_csr(stim_table[i].csr_index, stim_table[i].csr_value);
         else
            deliver(stim_table[i].item, stim_table[i].typed, stim_table[i].result);
      end
      directed_items = items_done;

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = 0;
         stall_pct = 0;
         case (p)
            0: set_levels(1'b1, 910, 9830, 1638, 0);
            1: set_levels(1'b1, 32768, 31130, 29491, 2000);
            default: set_random_levels();
         endcase
         rnd_now = (p == 0) ? 32'hFFFF_F000 : $urandom;
         hold_left = 0;
         send_idle_pct = send_pcts[p];
         stall_pct = stall_pcts[p];
         if (p == 0 || p == 3) hold_requests++;
         counted = 0;
         while (counted < 410) begin
            if (counted == 205) begin
               set_random_levels();
               counted++;
            end
            t = random_item();
            deliver(t, 0, none);
            if (t.func <= FUNC_FIRE) counted++;
         end
      end

      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d items (%0d directed, the rest random under four idle mixes).",
               items_done, directed_items);
      $display("Checked %0d results: %0d fired steps, %0d drops, %0d honour verdicts.",
               results_seen, n_fired, n_drops, n_verdicts);
      if (errors == 0 && awaited_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
